// File: rtl/dlpg_pkg.sv
// -----------------------------------------------------------------------------
// dlpg_pkg: shared constants for the line pixel generator
// Field widths, configuration register indexes, reset values and action codes.
// -----------------------------------------------------------------------------
package dlpg_pkg;

   // Port field widths
   localparam int COORD_W    = 16;
   localparam int CLIP_MIN_W = 11;
   localparam int CLIP_EXT_W = 12;
   localparam int STRIDE_W   = 13;
   localparam int WORD_W     = 32;
   localparam int PIX_W      = 12;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_X_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_Y_MIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STRIDE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BASE  = 3'd5;

   localparam logic [CLIP_MIN_W-1:0] RST_CLIP_X_MIN  = 11'd0;
   localparam logic [CLIP_EXT_W-1:0] RST_CLIP_WIDTH  = 12'd640;
   localparam logic [CLIP_MIN_W-1:0] RST_CLIP_Y_MIN  = 11'd0;
   localparam logic [CLIP_EXT_W-1:0] RST_CLIP_HEIGHT = 12'd480;
   localparam logic [STRIDE_W-1:0]   RST_ROW_STRIDE  = 13'd640;
   localparam logic [WORD_W-1:0]     RST_FRAME_BASE  = 32'd0;

   // Input action codes
   localparam logic ACTION_START   = 1'b0;
   localparam logic ACTION_ADVANCE = 1'b1;

endpackage

// File: rtl/dlpg_clamp.sv
// -----------------------------------------------------------------------------
// dlpg_clamp: clip-window clamp for one coordinate
// Clamps a signed coordinate to [min, min + extent] with window saturation.
// -----------------------------------------------------------------------------
module dlpg_clamp #(
   parameter int MAX_DIM = 2048,
   parameter int CW      = 12
) (
   input  logic signed [dlpg_pkg::COORD_W-1:0]    coord,
   input  logic        [dlpg_pkg::CLIP_MIN_W-1:0] win_min,
   input  logic        [dlpg_pkg::CLIP_EXT_W-1:0] win_ext,
   output logic        [CW-1:0]                   clamped
);

   localparam int WW = dlpg_pkg::COORD_W + 1;
   localparam logic [WW-1:0] MIN_LIMIT = WW'(MAX_DIM - 1);
   localparam logic [WW-1:0] EXT_LIMIT = WW'(MAX_DIM);

   logic        [WW-1:0] min_wide;
   logic        [WW-1:0] ext_wide;
   logic        [WW-1:0] lo;
   logic        [WW-1:0] hi;
   logic signed [WW-1:0] value;

   always_comb begin
      min_wide = WW'(win_min);
      ext_wide = WW'(win_ext);
      // saturate an oversized window
      lo       = (min_wide > MIN_LIMIT) ? MIN_LIMIT : min_wide;
      hi       = lo + ((ext_wide > EXT_LIMIT) ? EXT_LIMIT : ext_wide);
      value    = WW'(coord);
      if (value < $signed(lo)) begin
         clamped = lo[CW-1:0];
      end else if (value > $signed(hi)) begin
         clamped = hi[CW-1:0];
      end else begin
         clamped = value[CW-1:0];
      end
   end

endmodule

// File: rtl/dlpg_div_step.sv
// -----------------------------------------------------------------------------
// dlpg_div_step: one restoring division step
// Compares the partial remainder with the divisor and subtracts when it fits.
// -----------------------------------------------------------------------------
module dlpg_div_step #(
   parameter int CW = 12
) (
   input  logic [CW:0]   rem_cur,
   input  logic [CW-1:0] divisor,
   output logic          fits,
   output logic [CW-1:0] rem_next
);

   logic [CW:0] diff;

   always_comb begin
      diff     = rem_cur - {1'b0, divisor};
      fits     = (rem_cur >= {1'b0, divisor});
      // the kept remainder is always below the divisor
      rem_next = fits ? diff[CW-1:0] : rem_cur[CW-1:0];
   end

endmodule

// File: rtl/dda_line_pixel_generator_unit.sv
// -----------------------------------------------------------------------------
// dda_line_pixel_generator_unit: fixed-point DDA line rasterizer
// Clamps line endpoints into the clip window, derives per-step increments with
// one shared restoring divide step, and emits one framebuffer pixel per advance on an armed line.
// -----------------------------------------------------------------------------
//
//   channel  dir  handshake             beat contents
//   -------  ---  --------------------  ---------------------------------------
//   req_     in   req_valid/req_stall   action, start/end x/y, pixel_color
//   rsp_     out  rsp_valid/rsp_stall   pixel_x/y, pixel_addr, write_color, last
//   csr_     in   csr_write_en          csr_index, csr_write_data (no wait)
//
// A start beat runs capture, setup, then a divide pass per quotient bit (FRAC_BITS+1 bits)
// for x and again for y; a zero-length line returns to idle after setup.
// An advance beat rounds, multiplies by the stride and adds the base, waiting in the last
// step while rsp_stall holds the result register; with no line armed it is dropped.
// Reset is synchronous; it idles the block and loads the register defaults.
// req_stall is high while the sequencer is busy; a held result does not block the next beat.
// -----------------------------------------------------------------------------
module dda_line_pixel_generator_unit #(
   parameter int FRAC_BITS = 8,
   parameter int MAX_DIM   = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,

   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_action,
   input  logic signed [dlpg_pkg::COORD_W-1:0]    req_start_x,
   input  logic signed [dlpg_pkg::COORD_W-1:0]    req_start_y,
   input  logic signed [dlpg_pkg::COORD_W-1:0]    req_end_x,
   input  logic signed [dlpg_pkg::COORD_W-1:0]    req_end_y,
   input  logic        [dlpg_pkg::WORD_W-1:0]     req_pixel_color,

   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [dlpg_pkg::PIX_W-1:0]      rsp_pixel_x,
   output logic        [dlpg_pkg::PIX_W-1:0]      rsp_pixel_y,
   output logic        [dlpg_pkg::WORD_W-1:0]     rsp_pixel_addr,
   output logic        [dlpg_pkg::WORD_W-1:0]     rsp_write_color,
   output logic                                   rsp_last_pixel,

   // configuration write port
   input  logic                                   csr_write_en,
   input  logic        [dlpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [dlpg_pkg::CSR_DATA_W-1:0] csr_write_data
);

   // coordinate width: clamped values reach 2*MAX_DIM-1
   localparam int CW    = $clog2(2 * MAX_DIM);
   localparam int AW    = CW + FRAC_BITS;          // accumulator
   localparam int QW    = FRAC_BITS + 1;           // quotient magnitude, up to 2^FRAC_BITS
   localparam int IW    = FRAC_BITS + 2;           // signed increment
   localparam int CNT_W = $clog2(QW + 1);
   localparam int PW    = CW + dlpg_pkg::STRIDE_W; // row offset product

   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(QW - 1);
   localparam logic [AW:0]      HALF     =
      {{(AW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVX,
      ST_DIVY,
      ST_MUL,
      ST_ADDR
   } state_type;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [dlpg_pkg::CLIP_MIN_W-1:0] clip_x_min_ff;
   logic [dlpg_pkg::CLIP_EXT_W-1:0] clip_width_ff;
   logic [dlpg_pkg::CLIP_MIN_W-1:0] clip_y_min_ff;
   logic [dlpg_pkg::CLIP_EXT_W-1:0] clip_height_ff;
   logic [dlpg_pkg::STRIDE_W-1:0]   row_stride_ff;
   logic [dlpg_pkg::WORD_W-1:0]     frame_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_min_ff  <= dlpg_pkg::RST_CLIP_X_MIN;
         clip_width_ff  <= dlpg_pkg::RST_CLIP_WIDTH;
         clip_y_min_ff  <= dlpg_pkg::RST_CLIP_Y_MIN;
         clip_height_ff <= dlpg_pkg::RST_CLIP_HEIGHT;
         row_stride_ff  <= dlpg_pkg::RST_ROW_STRIDE;
         frame_base_ff  <= dlpg_pkg::RST_FRAME_BASE;
      end else if (csr_write_en) begin
         case (csr_index)
            dlpg_pkg::CSR_CLIP_X_MIN: begin
               clip_x_min_ff <= csr_write_data[dlpg_pkg::CLIP_MIN_W-1:0];
            end
            dlpg_pkg::CSR_CLIP_WIDTH: begin
               clip_width_ff <= csr_write_data[dlpg_pkg::CLIP_EXT_W-1:0];
            end
            dlpg_pkg::CSR_CLIP_Y_MIN: begin
               clip_y_min_ff <= csr_write_data[dlpg_pkg::CLIP_MIN_W-1:0];
            end
            dlpg_pkg::CSR_CLIP_HEIGHT: begin
               clip_height_ff <= csr_write_data[dlpg_pkg::CLIP_EXT_W-1:0];
            end
            dlpg_pkg::CSR_ROW_STRIDE: begin
               row_stride_ff <= csr_write_data[dlpg_pkg::STRIDE_W-1:0];
            end
            dlpg_pkg::CSR_FRAME_BASE: begin
               frame_base_ff <= csr_write_data[dlpg_pkg::WORD_W-1:0];
            end
            default: begin
               // writes to unused indexes are dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Endpoint clamps, taken straight from the request ports
   // ---------------------------------------------------------------------------
   logic [CW-1:0] clamp_x0;
   logic [CW-1:0] clamp_y0;
   logic [CW-1:0] clamp_x1;
   logic [CW-1:0] clamp_y1;

   dlpg_clamp #(.MAX_DIM(MAX_DIM), .CW(CW)) u_clamp_x0 (
      .coord(req_start_x), .win_min(clip_x_min_ff), .win_ext(clip_width_ff),
      .clamped(clamp_x0)
   );
   dlpg_clamp #(.MAX_DIM(MAX_DIM), .CW(CW)) u_clamp_y0 (
      .coord(req_start_y), .win_min(clip_y_min_ff), .win_ext(clip_height_ff),
      .clamped(clamp_y0)
   );
   dlpg_clamp #(.MAX_DIM(MAX_DIM), .CW(CW)) u_clamp_x1 (
      .coord(req_end_x), .win_min(clip_x_min_ff), .win_ext(clip_width_ff),
      .clamped(clamp_x1)
   );
   dlpg_clamp #(.MAX_DIM(MAX_DIM), .CW(CW)) u_clamp_y1 (
      .coord(req_end_y), .win_min(clip_y_min_ff), .win_ext(clip_height_ff),
      .clamped(clamp_y1)
   );

   // ---------------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [CW-1:0]          steps_left_ff, steps_left_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath registers (no reset needed)
   logic [CW-1:0]          x0_ff, x0_in;
   logic [CW-1:0]          y0_ff, y0_in;
   logic [CW-1:0]          x1_ff, x1_in;
   logic [CW-1:0]          y1_ff, y1_in;
   logic [CW-1:0]          steps_ff, steps_in;
   logic [CW-1:0]          ay_ff, ay_in;
   logic                   neg_x_ff, neg_x_in;
   logic                   neg_y_ff, neg_y_in;
   logic [CW:0]            rem_ff, rem_in;
   logic [QW-1:0]          quot_ff, quot_in;
   logic [IW-1:0]          x_inc_ff, x_inc_in;
   logic [IW-1:0]          y_inc_ff, y_inc_in;
   logic [AW-1:0]          x_acc_ff, x_acc_in;
   logic [AW-1:0]          y_acc_ff, y_acc_in;
   logic [dlpg_pkg::WORD_W-1:0] color_ff, color_in;
   logic [CW-1:0]          px_ff, px_in;
   logic [CW-1:0]          py_ff, py_in;
   logic                   last_ff, last_in;
   logic [PW-1:0]          prod_ff, prod_in;

   logic [dlpg_pkg::PIX_W-1:0]  rsp_pixel_x_ff, rsp_pixel_x_in;
   logic [dlpg_pkg::PIX_W-1:0]  rsp_pixel_y_ff, rsp_pixel_y_in;
   logic [dlpg_pkg::WORD_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [dlpg_pkg::WORD_W-1:0] rsp_color_ff, rsp_color_in;
   logic                        rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------------------
   // Shared divide step: |d| * 2^FRAC_BITS / steps, one quotient bit a cycle.
   // Since |d| <= steps, the integer part is a single bit, so the partial
   // remainder starts at |d| and FRAC_BITS zero bits are shifted in after it.
   // ---------------------------------------------------------------------------
   logic          div_fits;
   logic [CW-1:0] div_rem;

   dlpg_div_step #(.CW(CW)) u_div_step (
      .rem_cur (rem_ff),
      .divisor (steps_ff),
      .fits    (div_fits),
      .rem_next(div_rem)
   );

   // ---------------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------------
   logic          req_take;
   logic          out_free;
   logic [CW:0]   dx;
   logic [CW:0]   dy;
   logic [CW-1:0] ax;
   logic [CW-1:0] ay;
   logic [QW-1:0] quot_next;
   logic [IW-1:0] quot_ext;
   logic [AW:0]   x_round;
   logic [AW:0]   y_round;

   always_comb begin
      req_take  = req_valid && (state_ff == ST_IDLE);
      out_free  = !rsp_valid_ff || !rsp_stall;

      dx        = {1'b0, x1_ff} - {1'b0, x0_ff};
      dy        = {1'b0, y1_ff} - {1'b0, y0_ff};
      ax        = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      ay        = dy[CW] ? CW'(-dy) : dy[CW-1:0];

      quot_next = {quot_ff[QW-2:0], div_fits};
      quot_ext  = {1'b0, quot_next};

      x_round   = {1'b0, x_acc_ff} + HALF;
      y_round   = {1'b0, y_acc_ff} + HALF;

      // hold by default
      state_in      = state_ff;
      steps_left_in = steps_left_ff;
      bit_cnt_in    = bit_cnt_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      steps_in      = steps_ff;
      ay_in         = ay_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      x_inc_in      = x_inc_ff;
      y_inc_in      = y_inc_ff;
      x_acc_in      = x_acc_ff;
      y_acc_in      = y_acc_ff;
      color_in      = color_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;

      // drop the result beat once taken
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_pixel_x_in = rsp_pixel_x_ff;
      rsp_pixel_y_in = rsp_pixel_y_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == dlpg_pkg::ACTION_START) begin
                  x0_in    = clamp_x0;
                  y0_in    = clamp_y0;
                  x1_in    = clamp_x1;
                  y1_in    = clamp_y1;
                  color_in = req_pixel_color;
                  state_in = ST_SETUP;
               end else if (steps_left_ff != '0) begin
                  // round the current position, then advance the accumulators
                  px_in         = x_round[AW-1:FRAC_BITS];
                  py_in         = y_round[AW-1:FRAC_BITS];
                  last_in       = (steps_left_ff == CW'(1));
                  x_acc_in      = x_acc_ff + {{(AW - IW){x_inc_ff[IW-1]}}, x_inc_ff};
                  y_acc_in      = y_acc_ff + {{(AW - IW){y_inc_ff[IW-1]}}, y_inc_ff};
                  steps_left_in = steps_left_ff - CW'(1);
                  state_in      = ST_MUL;
               end
            end
         end

         ST_SETUP: begin
            // the previous line is abandoned here
            steps_left_in = '0;
            steps_in      = (ax > ay) ? ax : ay;
            ay_in         = ay;
            neg_x_in      = dx[CW];
            neg_y_in      = dy[CW];
            rem_in        = {1'b0, ax};
            quot_in       = '0;
            bit_cnt_in    = '0;
            x_acc_in      = {x0_ff, {FRAC_BITS{1'b0}}};
            y_acc_in      = {y0_ff, {FRAC_BITS{1'b0}}};
            if ((ax == '0) && (ay == '0)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIVX;
            end
         end

         ST_DIVX: begin
            quot_in    = quot_next;
            rem_in     = {div_rem, 1'b0};
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == LAST_BIT) begin
               x_inc_in   = neg_x_ff ? IW'(-quot_ext) : quot_ext;
               rem_in     = {1'b0, ay_ff};
               quot_in    = '0;
               bit_cnt_in = '0;
               state_in   = ST_DIVY;
            end
         end

         ST_DIVY: begin
            quot_in    = quot_next;
            rem_in     = {div_rem, 1'b0};
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == LAST_BIT) begin
               y_inc_in      = neg_y_ff ? IW'(-quot_ext) : quot_ext;
               steps_left_in = steps_ff;
               state_in      = ST_IDLE;
            end
         end

         ST_MUL: begin
            prod_in  = PW'(py_ff) * PW'(row_stride_ff);
            state_in = ST_ADDR;
         end

         ST_ADDR: begin
            // wait for the result register to free up
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pixel_x_in = dlpg_pkg::PIX_W'(px_ff);
               rsp_pixel_y_in = dlpg_pkg::PIX_W'(py_ff);
               rsp_addr_in    = frame_base_ff + dlpg_pkg::WORD_W'(px_ff)
                              + dlpg_pkg::WORD_W'(prod_ff);
               rsp_color_in   = color_ff;
               rsp_last_in    = last_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // State and registered outputs
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steps_left_ff <= '0;
         bit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steps_left_ff <= steps_left_in;
         bit_cnt_ff    <= bit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x0_ff          <= x0_in;
      y0_ff          <= y0_in;
      x1_ff          <= x1_in;
      y1_ff          <= y1_in;
      steps_ff       <= steps_in;
      ay_ff          <= ay_in;
      neg_x_ff       <= neg_x_in;
      neg_y_ff       <= neg_y_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      x_inc_ff       <= x_inc_in;
      y_inc_ff       <= y_inc_in;
      x_acc_ff       <= x_acc_in;
      y_acc_ff       <= y_acc_in;
      color_ff       <= color_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      last_ff        <= last_in;
      prod_ff        <= prod_in;
      rsp_pixel_x_ff <= rsp_pixel_x_in;
      rsp_pixel_y_ff <= rsp_pixel_y_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // ---------------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------------
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_pixel_x_ff;
   assign rsp_pixel_y     = rsp_pixel_y_ff;
   assign rsp_pixel_addr  = rsp_addr_ff;
   assign rsp_write_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule

// File: tb/dda_line_pixel_generator_unit_tb.sv
// -----------------------------------------------------------------------------
// dda_line_pixel_generator_unit_tb: self-checking bench for the line rasterizer
// Drives start and advance beats under random idling and back-pressure, runs a
// local fixed-point DDA predictor and compares each pixel beat field by field.
// -----------------------------------------------------------------------------
module dda_line_pixel_generator_unit_tb;

   localparam int FRAC_BITS     = 8;
   localparam int MAX_DIM       = 2048;
   localparam int ONE           = 1 << FRAC_BITS;
   localparam int HALF          = ONE / 2;
   // long enough for a start beat to run out; leave margin on top
   localparam int SETTLE_CYCLES = 2 * FRAC_BITS + 16;
   localparam int CYCLE_LIMIT   = 300000;
   // indexes with no register behind them
   localparam logic [dlpg_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [dlpg_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [dlpg_pkg::PIX_W-1:0]  x;
      logic [dlpg_pkg::PIX_W-1:0]  y;
      logic [dlpg_pkg::WORD_W-1:0] addr;
      logic [dlpg_pkg::WORD_W-1:0] color;
      logic                        last;
   } pixel_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_action;
   logic signed [dlpg_pkg::COORD_W-1:0]  req_start_x;
   logic signed [dlpg_pkg::COORD_W-1:0]  req_start_y;
   logic signed [dlpg_pkg::COORD_W-1:0]  req_end_x;
   logic signed [dlpg_pkg::COORD_W-1:0]  req_end_y;
   logic        [dlpg_pkg::WORD_W-1:0]   req_pixel_color;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic        [dlpg_pkg::PIX_W-1:0]    rsp_pixel_x;
   logic        [dlpg_pkg::PIX_W-1:0]    rsp_pixel_y;
   logic        [dlpg_pkg::WORD_W-1:0]   rsp_pixel_addr;
   logic        [dlpg_pkg::WORD_W-1:0]   rsp_write_color;
   logic                                 rsp_last_pixel;
   logic                                 csr_write_en;
   logic        [dlpg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic        [dlpg_pkg::CSR_DATA_W-1:0]  csr_write_data;

   // predictor copy of the registers and the line state
   logic [dlpg_pkg::CLIP_MIN_W-1:0] cfg_x_min;
   logic [dlpg_pkg::CLIP_EXT_W-1:0] cfg_width;
   logic [dlpg_pkg::CLIP_MIN_W-1:0] cfg_y_min;
   logic [dlpg_pkg::CLIP_EXT_W-1:0] cfg_height;
   logic [dlpg_pkg::STRIDE_W-1:0]   cfg_stride;
   logic [dlpg_pkg::WORD_W-1:0]     cfg_base;
   logic signed [23:0]              ln_x_acc;
   logic signed [23:0]              ln_y_acc;
   logic signed [9:0]               ln_x_inc;
   logic signed [9:0]               ln_y_inc;
   logic [12:0]                     ln_steps_left;
   logic [dlpg_pkg::WORD_W-1:0]     ln_color;

   pixel_type expected_pixels[$];
   int        error_count;
   int        cycle_count;
   bit        gap_enable;
   bit        stall_enable;
   int        hold_off_left;
   int        stall_burst_left;

   dda_line_pixel_generator_unit #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_DIM   (MAX_DIM)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_addr  (rsp_pixel_addr),
      .rsp_write_color (rsp_write_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Clip window arithmetic: saturate the minimum to MAX_DIM-1 and the extent to
   // MAX_DIM; the far edge is inclusive.
   // ---------------------------------------------------------------------------
   function automatic int win_lo(int min_reg);
      return (min_reg > MAX_DIM - 1) ? MAX_DIM - 1 : min_reg;
   endfunction

   function automatic int win_hi(int min_reg, int ext_reg);
      return win_lo(min_reg) + ((ext_reg > MAX_DIM) ? MAX_DIM : ext_reg);
   endfunction

   function automatic int clamp_coord(int v, int min_reg, int ext_reg);
      if (v < win_lo(min_reg)) return win_lo(min_reg);
      if (v > win_hi(min_reg, ext_reg)) return win_hi(min_reg, ext_reg);
      return v;
   endfunction

   // number of pixels a start beat arms under the current window
   function automatic int line_steps(int sx, int sy, int ex, int ey);
      int dx;
      int dy;
      dx = clamp_coord(ex, cfg_x_min, cfg_width) - clamp_coord(sx, cfg_x_min, cfg_width);
      dy = clamp_coord(ey, cfg_y_min, cfg_height) - clamp_coord(sy, cfg_y_min, cfg_height);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx > dy) ? dx : dy;
   endfunction

   // ---------------------------------------------------------------------------
   // Predictor: a start beat loads the DDA, an advance beat on an armed line
   // yields one pixel and steps the accumulators.
   // ---------------------------------------------------------------------------
   task automatic rasterize_beat(input logic action,
                                 input logic signed [dlpg_pkg::COORD_W-1:0] sx, sy, ex, ey,
                                 input logic [dlpg_pkg::WORD_W-1:0] color);
      int        x0;
      int        y0;
      int        dx;
      int        dy;
      int        steps;
      int        px;
      int        py;
      pixel_type pix;
      if (action == dlpg_pkg::ACTION_START) begin
         x0    = clamp_coord(sx, cfg_x_min, cfg_width);
         y0    = clamp_coord(sy, cfg_y_min, cfg_height);
         dx    = clamp_coord(ex, cfg_x_min, cfg_width) - x0;
         dy    = clamp_coord(ey, cfg_y_min, cfg_height) - y0;
         steps = line_steps(sx, sy, ex, ey);
         ln_color = color;
         if (steps == 0) begin
            // degenerate line: stay idle
            ln_steps_left = '0;
         end else begin
            // signed division truncates toward zero
            ln_x_inc      = 10'((dx * ONE) / steps);
            ln_y_inc      = 10'((dy * ONE) / steps);
            ln_x_acc      = 24'(x0 * ONE);
            ln_y_acc      = 24'(y0 * ONE);
            ln_steps_left = 13'(steps);
         end
      end else if (ln_steps_left != 0) begin
         px        = (int'(ln_x_acc) + HALF) >>> FRAC_BITS;
         py        = (int'(ln_y_acc) + HALF) >>> FRAC_BITS;
         pix.x     = px[dlpg_pkg::PIX_W-1:0];
         pix.y     = py[dlpg_pkg::PIX_W-1:0];
         pix.addr  = cfg_base + 32'(px) + 32'(py) * 32'(cfg_stride);
         pix.color = ln_color;
         pix.last  = (ln_steps_left == 1);
         expected_pixels.insert(expected_pixels.size(), pix);
         ln_x_acc      = ln_x_acc + ln_x_inc;
         ln_y_acc      = ln_y_acc + ln_y_inc;
         ln_steps_left = ln_steps_left - 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input logic [dlpg_pkg::WORD_W-1:0] want,
                                input logic [dlpg_pkg::WORD_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Check the pixel beat
   // first, then fold register writes and accepted request beats into the model.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         cfg_x_min     = dlpg_pkg::RST_CLIP_X_MIN;
         cfg_width     = dlpg_pkg::RST_CLIP_WIDTH;
         cfg_y_min     = dlpg_pkg::RST_CLIP_Y_MIN;
         cfg_height    = dlpg_pkg::RST_CLIP_HEIGHT;
         cfg_stride    = dlpg_pkg::RST_ROW_STRIDE;
         cfg_base      = dlpg_pkg::RST_FRAME_BASE;
         ln_x_acc      = '0;
         ln_y_acc      = '0;
         ln_x_inc      = '0;
         ln_y_inc      = '0;
         ln_steps_left = '0;
         ln_color      = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected pixel beat, expected none, actual x=%0d y=%0d addr=0x%0h",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_pixel_addr);
            end else begin
               want = expected_pixels.pop_front();
               compare_field("pixel_x", want.x, rsp_pixel_x);
               compare_field("pixel_y", want.y, rsp_pixel_y);
               compare_field("pixel_addr", want.addr, rsp_pixel_addr);
               compare_field("write_color", want.color, rsp_write_color);
               compare_field("last_pixel", want.last, rsp_last_pixel);
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               dlpg_pkg::CSR_CLIP_X_MIN:
                  cfg_x_min  = csr_write_data[dlpg_pkg::CLIP_MIN_W-1:0];
               dlpg_pkg::CSR_CLIP_WIDTH:
                  cfg_width  = csr_write_data[dlpg_pkg::CLIP_EXT_W-1:0];
               dlpg_pkg::CSR_CLIP_Y_MIN:
                  cfg_y_min  = csr_write_data[dlpg_pkg::CLIP_MIN_W-1:0];
               dlpg_pkg::CSR_CLIP_HEIGHT:
                  cfg_height = csr_write_data[dlpg_pkg::CLIP_EXT_W-1:0];
               dlpg_pkg::CSR_ROW_STRIDE:
                  cfg_stride = csr_write_data[dlpg_pkg::STRIDE_W-1:0];
               dlpg_pkg::CSR_FRAME_BASE:
                  cfg_base   = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            rasterize_beat(req_action, req_start_x, req_start_y, req_end_x, req_end_y,
                           req_pixel_color);
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixel beats outstanding", $time,
                  expected_pixels.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus a long hold-off when a test asks for it.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     = 1'b1;
         hold_off_left = hold_off_left - 1;
      end else if (stall_burst_left > 0) begin
         rsp_stall        = 1'b1;
         stall_burst_left = stall_burst_left - 1;
      end else if (stall_enable && $urandom_range(0, 5) == 0) begin
         rsp_stall        = 1'b1;
         stall_burst_left = $urandom_range(0, 3);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Sender helpers: drive at the falling edge, hold the beat until accepted.
   // Valid stays high on return so back-to-back beats need no re-raise.
   // ---------------------------------------------------------------------------
   task automatic send_beat(input logic action,
                            input logic signed [dlpg_pkg::COORD_W-1:0] sx, sy, ex, ey,
                            input logic [dlpg_pkg::WORD_W-1:0] color);
      @(negedge clock);
      if (gap_enable && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_action      = action;
      req_start_x     = sx;
      req_start_y     = sy;
      req_end_x       = ex;
      req_end_y       = ey;
      req_pixel_color = color;
      do @(posedge clock); while (req_stall);
   endtask

   // advance fields other than the action are don't-care: fill them with noise
   task automatic send_advance();
      send_beat(dlpg_pkg::ACTION_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), $urandom);
   endtask

   // Drop valid, drain every expected pixel, then let a start beat run out.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dlpg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dlpg_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en   = 1'b0;
   endtask

   // Program the whole window; junk in the bits above each narrower register must be ignored.
   task automatic set_window(input int x_min, input int width, input int y_min,
                             input int height, input int stride, input logic [31:0] base);
      write_csr(dlpg_pkg::CSR_CLIP_X_MIN,
                ($urandom << dlpg_pkg::CLIP_MIN_W) | 32'(x_min));
      write_csr(dlpg_pkg::CSR_CLIP_WIDTH,
                ($urandom << dlpg_pkg::CLIP_EXT_W) | 32'(width));
      write_csr(dlpg_pkg::CSR_CLIP_Y_MIN,
                ($urandom << dlpg_pkg::CLIP_MIN_W) | 32'(y_min));
      write_csr(dlpg_pkg::CSR_CLIP_HEIGHT,
                ($urandom << dlpg_pkg::CLIP_EXT_W) | 32'(height));
      write_csr(dlpg_pkg::CSR_ROW_STRIDE,
                ($urandom << dlpg_pkg::STRIDE_W) | 32'(stride));
      write_csr(dlpg_pkg::CSR_FRAME_BASE, base);
      write_csr(CSR_SPARE_LO, $urandom);
      write_csr(CSR_SPARE_HI, $urandom);
   endtask

   // Endpoint generation: anchor on an edge or inside the window, jitter a bit,
   // and now and then throw in a raw 16-bit value that clamps hard.
   function automatic int pick_anchor(int lo, int hi);
      case ($urandom_range(0, 2))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic logic signed [dlpg_pkg::COORD_W-1:0] pick_coord(int anchor, int spread);
      if ($urandom_range(0, 7) == 0) return 16'($urandom);
      return 16'(anchor + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // Random well-formed lines with some noise: stray advances, overruns and
   // lines cut short by the next start.
   task automatic run_line_batch(input int target);
      int sent;
      int steps;
      int n;
      int i;
      int spread;
      int anchor_x;
      int anchor_y;
      logic signed [dlpg_pkg::COORD_W-1:0] sx, sy, ex, ey;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_advance();
         end else begin
            spread   = ($urandom_range(0, 3) == 0) ? 40 : 8;
            anchor_x = pick_anchor(win_lo(cfg_x_min), win_hi(cfg_x_min, cfg_width));
            anchor_y = pick_anchor(win_lo(cfg_y_min), win_hi(cfg_y_min, cfg_height));
            sx = pick_coord(anchor_x, spread);
            sy = pick_coord(anchor_y, spread);
            ex = pick_coord(anchor_x, spread);
            ey = pick_coord(anchor_y, spread);
            steps = line_steps(sx, sy, ex, ey);
            send_beat(dlpg_pkg::ACTION_START, sx, sy, ex, ey, $urandom);
            sent++;
            n = steps;
            if (steps > 64)
               n = $urandom_range(1, 64);
            else if ($urandom_range(0, 7) == 0)
               n = steps + $urandom_range(1, 2);
            else if ($urandom_range(0, 7) == 0)
               n = $urandom_range(0, steps);
            for (i = 0; i < n; i++) begin
               send_advance();
               if (i < steps) sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset window: a line whose start point clamps at the origin, plus an overrun.
   task automatic test_default_window();
      int i;
      send_beat(dlpg_pkg::ACTION_START, -16'sd1, -16'sd1, 16'sd3, 16'sd1, 32'hA5A5_5A5A);
      for (i = 0; i < 4; i++) send_advance();
   endtask

   // Tiny window: hard clamps at both edges, zero length, idle advance,
   // restart mid-line, vertical line, address wrap and extreme colors.
   task automatic test_directed_cases();
      int i;
      wait_idle();
      set_window(100, 3, 200, 2, 8191, 32'hFFFF_FFF0);
      send_beat(dlpg_pkg::ACTION_START, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                32'hFFFF_FFFF);
      for (i = 0; i < 4; i++) send_advance();
      send_beat(dlpg_pkg::ACTION_START, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
      send_advance();
      send_beat(dlpg_pkg::ACTION_START, 16'sd100, 16'sd200, 16'sd103, 16'sd202,
                32'h1234_5678);
      send_advance();
      // abandon the line above after one pixel
      send_beat(dlpg_pkg::ACTION_START, 16'sd103, 16'sd202, 16'sd100, 16'sd200,
                32'h5A5A_A5A5);
      for (i = 0; i < 3; i++) send_advance();
      send_beat(dlpg_pkg::ACTION_START, 16'sd101, 16'sd199, 16'sd101, 16'sd205,
                32'h8000_0001);
      for (i = 0; i < 2; i++) send_advance();
   endtask

   // Hold the receiver off while a long line is fed so the block backs up.
   task automatic test_backpressure();
      int i;
      wait_idle();
      set_window(0, 2048, 0, 2048, 640, 32'h0010_0000);
      hold_off_left = 150;
      send_beat(dlpg_pkg::ACTION_START, 16'sd0, 16'sd0, 16'sd90, 16'sd37, $urandom);
      for (i = 0; i < 90; i++) send_advance();
   endtask

   // Several window settings, extremes first, random lines with idling.
   task automatic test_random_lines();
      int p;
      for (p = 0; p < 7; p++) begin
         wait_idle();
         case (p)
            0:       set_window(2047, 4095, 2047, 2048, 8191, 32'hFFFF_FFFF);
            1:       set_window(0, 1, 0, 0, 0, 32'h0000_0000);
            2:       set_window(3, 0, 0, 2048, 1, 32'h8000_0000);
            default: set_window($urandom_range(0, 2047),
                                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                            : $urandom_range(1, 48),
                                $urandom_range(0, 2047),
                                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                            : $urandom_range(1, 48),
                                $urandom_range(0, 8191), $urandom);
         endcase
         run_line_batch(90);
      end
   endtask

   // Last stretch at full rate on both sides.
   task automatic test_quiet_tail();
      wait_idle();
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      set_window($urandom_range(0, 2047), $urandom_range(1, 48), $urandom_range(0, 2047),
                 $urandom_range(1, 48), $urandom_range(0, 8191), $urandom);
      run_line_batch(80);
   endtask

   initial begin
      error_count      = 0;
      cycle_count      = 0;
      hold_off_left    = 0;
      stall_burst_left = 0;
      gap_enable       = 1'b1;
      stall_enable     = 1'b1;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = dlpg_pkg::ACTION_START;
      req_start_x      = '0;
      req_start_y      = '0;
      req_end_x        = '0;
      req_end_y        = '0;
      req_pixel_color  = '0;
      rsp_stall        = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_window();
      test_directed_cases();
      test_backpressure();
      test_random_lines();
      test_quiet_tail();
      wait_idle();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
